/* src/infix_to_prefix_converter_top_assert.svh */
// ----------------------------------------------------------------------------
// infix to prefix converter assertion macros
// concurrent checks used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_PREFIX_CONVERTER_TOP_ASSERT_SVH
`define INFIX_TO_PREFIX_CONVERTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// expression must never hold outside reset
`define ITP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error(msg);
// antecedent implies consequent in the same cycle
`define ITP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ITP_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`define ITP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ITP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/itp_pkg.sv */
// ----------------------------------------------------------------------------
// infix to prefix converter package
// sequencer states, character codes and operator classification
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int SYM_W = 8;

    // characters with a special role
    localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;

    typedef logic [1:0] t_rank;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_POP_EV,
        ST_DRAIN_RD,
        ST_DRAIN_EV,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    // operator priority, zero for anything that is not an operator
    function automatic t_rank rank_of(input logic [SYM_W-1:0] c);
        t_rank r;
        r = 2'd0;
        if (c == CH_CARET) begin
            r = 2'd3;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            r = 2'd2;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            r = 2'd1;
        end
        return r;
    endfunction

    // digits and letters
    function automatic logic is_operand(input logic [SYM_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

endpackage

/* src/infix_to_prefix_converter_top.sv */
// ----------------------------------------------------------------------------
// infix to prefix converter
// buffers an infix expression, scans it backwards with an operator stack
// and streams the prefix form
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata = symbol, tlast = last
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata = symbol_res,
//                                                tlast = last_res,
//                                                tuser = empty_res, overflow
//
//  characters load one per cycle; after the request marked last the scan
//  reads and evaluates each character; an operator or open paren meeting
//  a non-empty stack reads the stack top, and each pop reads the next top
//  (registered reads); results are read back from the output store.
//  no clearing pass after reset; input is refused from the last request
//  until the final result enters the result register, where it may wait.
// ----------------------------------------------------------------------------
`include "infix_to_prefix_converter_top_assert.svh"

module infix_to_prefix_converter_top #(
    parameter int MAX_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic       s_axis_tlast,   // last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] symbol_res
    output logic       m_axis_tlast,   // last_res
    output logic [1:0] m_axis_tuser    // [0] empty_res, [1] overflow
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_LEN);
    localparam logic [CW-1:0] ONE  = CW'(1);

    // sequencer and counters
    itp_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_in_cnt, n_in_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_sp, n_sp;
    logic [CW-1:0] r_out_cnt, n_out_cnt;
    logic [CW-1:0] r_k, n_k;
    logic          r_drop, n_drop;
    logic          r_ovf, n_ovf;

    // result register
    logic                     r_o_valid, n_o_valid;
    logic [itp_pkg::SYM_W-1:0] r_o_sym, n_o_sym;
    logic                     r_o_last, n_o_last;
    logic                     r_o_empty, n_o_empty;
    logic                     r_o_ovf, n_o_ovf;

    // memories
    logic [itp_pkg::SYM_W-1:0] in_mem  [MAX_LEN];
    logic [itp_pkg::SYM_W-1:0] stk_mem [MAX_LEN];
    logic [itp_pkg::SYM_W-1:0] out_mem [MAX_LEN];
    logic [itp_pkg::SYM_W-1:0] r_in_rd, r_stk_rd, r_out_rd;

    logic          in_we, in_re;
    logic [AW-1:0] in_waddr, in_raddr;
    logic          stk_we, stk_re;
    logic [AW-1:0] stk_waddr, stk_raddr;
    logic [itp_pkg::SYM_W-1:0] stk_wdata;
    logic          out_we, out_re;
    logic [AW-1:0] out_waddr, out_raddr;
    logic [itp_pkg::SYM_W-1:0] out_wdata;

    // shared stack and output helpers
    logic                     emit_req, push_req;
    logic [itp_pkg::SYM_W-1:0] emit_char, push_char;
    logic [CW-1:0]            sp_dec, in_cnt_inc;
    logic                     do_pop, out_free;

    assign s_axis_tready = (r_state == itp_pkg::ST_LOAD);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_sym;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = {r_o_ovf, r_o_empty};

    assign sp_dec     = r_sp - ONE;
    assign in_cnt_inc = r_in_cnt + ONE;
    assign out_free   = !r_o_valid || m_axis_tready;

    // pop decision against the stack top just read
    always_comb begin
        if (r_in_rd == itp_pkg::CH_LPAREN) begin
            do_pop = (r_stk_rd != itp_pkg::CH_RPAREN);
        end else begin
            do_pop = (itp_pkg::rank_of(r_stk_rd) > itp_pkg::rank_of(r_in_rd));
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_in_cnt  = r_in_cnt;
        n_idx     = r_idx;
        n_sp      = r_sp;
        n_k       = r_k;
        n_drop    = r_drop;
        n_ovf     = r_ovf;
        n_o_valid = r_o_valid && !m_axis_tready;
        n_o_sym   = r_o_sym;
        n_o_last  = r_o_last;
        n_o_empty = r_o_empty;
        n_o_ovf   = r_o_ovf;
        in_we     = 1'b0;
        in_waddr  = r_in_cnt[AW-1:0];
        in_re     = 1'b0;
        in_raddr  = sp_dec[AW-1:0];
        stk_re    = 1'b0;
        stk_raddr = sp_dec[AW-1:0];
        out_re    = 1'b0;
        out_raddr = sp_dec[AW-1:0];
        emit_req  = 1'b0;
        emit_char = r_in_rd;
        push_req  = 1'b0;
        push_char = r_in_rd;

        unique case (r_state)
            itp_pkg::ST_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_in_cnt < FULL) begin
                        in_we    = 1'b1;
                        n_in_cnt = in_cnt_inc;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_ovf   = r_drop || (r_in_cnt >= FULL);
                        n_idx   = n_in_cnt;
                        n_state = itp_pkg::ST_SCAN_RD;
                    end
                end
            end
            itp_pkg::ST_SCAN_RD: begin
                if (r_idx == '0) begin
                    n_state = itp_pkg::ST_DRAIN_RD;
                end else begin
                    in_re    = 1'b1;
                    n_idx    = r_idx - ONE;
                    in_raddr = n_idx[AW-1:0];
                    n_state  = itp_pkg::ST_SCAN_EV;
                end
            end
            itp_pkg::ST_SCAN_EV: begin
                if (itp_pkg::is_operand(r_in_rd)) begin
                    emit_req = 1'b1;
                    n_state  = itp_pkg::ST_SCAN_RD;
                end else if (r_in_rd == itp_pkg::CH_RPAREN) begin
                    push_req = 1'b1;
                    n_state  = itp_pkg::ST_SCAN_RD;
                end else if (r_sp == '0) begin
                    // an unmatched open paren pops nothing
                    push_req = (r_in_rd != itp_pkg::CH_LPAREN);
                    n_state  = itp_pkg::ST_SCAN_RD;
                end else begin
                    stk_re  = 1'b1;
                    n_state = itp_pkg::ST_POP_EV;
                end
            end
            itp_pkg::ST_POP_EV: begin
                if (do_pop) begin
                    emit_req  = 1'b1;
                    emit_char = r_stk_rd;
                    n_sp      = sp_dec;
                    n_state   = itp_pkg::ST_SCAN_EV;
                end else if (r_in_rd == itp_pkg::CH_LPAREN) begin
                    // discard the matching close paren
                    n_sp    = sp_dec;
                    n_state = itp_pkg::ST_SCAN_RD;
                end else begin
                    push_req = 1'b1;
                    n_state  = itp_pkg::ST_SCAN_RD;
                end
            end
            itp_pkg::ST_DRAIN_RD: begin
                if (r_sp == '0) begin
                    n_k     = r_out_cnt;
                    n_state = itp_pkg::ST_EMIT_RD;
                end else begin
                    stk_re  = 1'b1;
                    n_state = itp_pkg::ST_DRAIN_EV;
                end
            end
            itp_pkg::ST_DRAIN_EV: begin
                emit_req  = 1'b1;
                emit_char = r_stk_rd;
                n_sp      = sp_dec;
                n_state   = itp_pkg::ST_DRAIN_RD;
            end
            itp_pkg::ST_EMIT_RD: begin
                if (out_free) begin
                    if (r_k == '0) begin
                        // nothing to emit: a single empty result
                        n_o_valid = 1'b1;
                        n_o_sym   = '0;
                        n_o_last  = 1'b1;
                        n_o_empty = 1'b1;
                        n_o_ovf   = r_ovf;
                        n_in_cnt  = '0;
                        n_sp      = '0;
                        n_drop    = 1'b0;
                        n_state   = itp_pkg::ST_LOAD;
                    end else begin
                        out_re    = 1'b1;
                        n_k       = r_k - ONE;
                        out_raddr = n_k[AW-1:0];
                        n_state   = itp_pkg::ST_EMIT_WR;
                    end
                end
            end
            itp_pkg::ST_EMIT_WR: begin
                n_o_valid = 1'b1;
                n_o_sym   = r_out_rd;
                n_o_last  = (r_k == '0);
                n_o_empty = 1'b0;
                n_o_ovf   = r_ovf;
                if (r_k == '0) begin
                    n_in_cnt = '0;
                    n_sp     = '0;
                    n_drop   = 1'b0;
                    n_state  = itp_pkg::ST_LOAD;
                end else begin
                    n_state = itp_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                n_state = itp_pkg::ST_LOAD;
            end
        endcase

        // output store append, dropped when full
        out_we    = emit_req && (r_out_cnt < FULL);
        out_waddr = r_out_cnt[AW-1:0];
        out_wdata = emit_char;
        if (r_state == itp_pkg::ST_LOAD || n_state == itp_pkg::ST_LOAD) begin
            n_out_cnt = '0;
        end else if (out_we) begin
            n_out_cnt = r_out_cnt + ONE;
        end else begin
            n_out_cnt = r_out_cnt;
        end

        // stack push, dropped when full
        stk_we    = push_req && (r_sp < FULL);
        stk_waddr = r_sp[AW-1:0];
        stk_wdata = push_char;
        if (stk_we) begin
            n_sp = r_sp + ONE;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= itp_pkg::ST_LOAD;
            r_in_cnt  <= '0;
            r_idx     <= '0;
            r_sp      <= '0;
            r_out_cnt <= '0;
            r_k       <= '0;
            r_drop    <= 1'b0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_in_cnt  <= n_in_cnt;
            r_idx     <= n_idx;
            r_sp      <= n_sp;
            r_out_cnt <= n_out_cnt;
            r_k       <= n_k;
            r_drop    <= n_drop;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_o_sym   <= n_o_sym;
        r_o_last  <= n_o_last;
        r_o_empty <= n_o_empty;
        r_o_ovf   <= n_o_ovf;
    end

    // input store
    always_ff @(posedge i_clk) begin
        if (in_we) begin
            in_mem[in_waddr] <= s_axis_tdata;
        end
        if (in_re) begin
            r_in_rd <= in_mem[in_raddr];
        end
    end

    // operator stack
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_rd <= stk_mem[stk_raddr];
        end
    end

    // output store
    always_ff @(posedge i_clk) begin
        if (out_we) begin
            out_mem[out_waddr] <= out_wdata;
        end
        if (out_re) begin
            r_out_rd <= out_mem[out_raddr];
        end
    end

    // every stored character yields at most one stack entry or result
    `ITP_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, ({1'b0, r_out_cnt} + {1'b0, r_sp}) > {1'b0, r_in_cnt}, "results plus stack exceed stored characters")
    // an empty result is always the final one
    `ITP_ASSERT_IMPLY(a_empty_last, i_clk, i_rst_n, r_o_valid && r_o_empty, r_o_last, "empty result without last")
    // a result load leaves the result register valid and the sequence in order
    `ITP_ASSERT_NEXT(a_emit_free, i_clk, i_rst_n, r_state == itp_pkg::ST_EMIT_WR, r_o_valid && (r_k == $past(r_k) || r_k == '0 || r_state == itp_pkg::ST_EMIT_RD), "result load out of sequence")

endmodule
